// ----- hw/rtl/sff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_pkg
// Shared constants and types for the folded symmetric FIR filter.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int COEF_IDX_W = 6;
  localparam int SHIFT_W    = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

  // item kinds carried on in_tuser
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // sequencer to datapath control
  typedef struct packed {
    logic clr_acc;
    logic issue;
    logic last;
    logic shift_en;
  } mac_ctl_t;

endpackage

// ----- hw/rtl/sff_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int W = 16,
  parameter int D = 93,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rq
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule

// ----- hw/rtl/sff_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_mac
// Pre-add, multiply and accumulate pipeline with output shift and saturation.
// ----------------------------------------------------------------------------
module sff_mac
  import sff_pkg::*;
#(
  parameter int TAPS        = 93,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] dl_qa,
  input  logic signed [SAMPLE_BITS-1:0] dl_qb,
  input  logic signed [COEF_BITS-1:0]   cf_q,
  input  logic [SHIFT_W-1:0]            shift_amt,
  output logic                          acc_done,
  output logic [SAMPLE_BITS-1:0]        sat_val,
  output logic                          sat_clip
);

  localparam int HALF   = (TAPS - 1) / 2;
  localparam int PRE_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = PRE_W + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(HALF + 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic                          d_vld_r, d_last_r;
  logic                          p_vld_r, p_last_r;
  logic                          m_vld_r, m_last_r;
  logic signed [SAMPLE_BITS-1:0] b_sel;
  logic signed [PRE_W-1:0]       pre_c, pre_r;
  logic signed [COEF_BITS-1:0]   coef_r;
  logic signed [PROD_W-1:0]      prod_c, prod_r;
  logic signed [ACC_W-1:0]       acc_r, sh_r;

  // middle tap has no partner
  assign b_sel  = d_last_r ? '0 : dl_qb;
  assign pre_c  = PRE_W'(dl_qa) + PRE_W'(b_sel);
  assign prod_c = pre_r * coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r  <= 1'b0;
      d_last_r <= 1'b0;
      p_vld_r  <= 1'b0;
      p_last_r <= 1'b0;
      m_vld_r  <= 1'b0;
      m_last_r <= 1'b0;
    end else begin
      d_vld_r  <= ctl.issue;
      d_last_r <= ctl.last;
      p_vld_r  <= d_vld_r;
      p_last_r <= d_last_r;
      m_vld_r  <= p_vld_r;
      m_last_r <= p_last_r;
    end
  end

  always_ff @(posedge clk) begin
    pre_r  <= pre_c;
    coef_r <= cf_q;
    prod_r <= prod_c;
    if (ctl.clr_acc) begin
      acc_r <= '0;
    end else if (m_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.shift_en) begin
      sh_r <= acc_r >>> shift_amt;
    end
  end

  assign acc_done = m_vld_r && m_last_r;

  always_comb begin
    if (sh_r > SAT_MAX) begin
      sat_val  = SAT_MAX[SAMPLE_BITS-1:0];
      sat_clip = 1'b1;
    end else if (sh_r < SAT_MIN) begin
      sat_val  = SAT_MIN[SAMPLE_BITS-1:0];
      sat_clip = 1'b1;
    end else begin
      sat_val  = sh_r[SAMPLE_BITS-1:0];
      sat_clip = 1'b0;
    end
  end

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> !p_vld_r && !d_vld_r)
    else $error("more taps in flight after the last tap");

endmodule

// ----- hw/rtl/sff_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_seq
// Sequencer: clearing pass, delay line pointers, tap stepping and handshake.
// ----------------------------------------------------------------------------
module sff_seq
  import sff_pkg::*;
#(
  parameter int TAPS        = 93,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  localparam int HALF  = (TAPS - 1) / 2,
  localparam int PTR_W = $clog2(TAPS),
  localparam int CA_W  = $clog2(HALF + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [COEF_IDX_W-1:0]  in_coef_idx,
  input  logic [COEF_BITS-1:0]   in_coef_val,
  output logic                   in_ready,
  input  logic                   out_busy,
  input  logic                   acc_done,
  output logic                   ld_out,
  output mac_ctl_t               ctl,
  output logic                   dl_we,
  output logic [PTR_W-1:0]       dl_wa,
  output logic [SAMPLE_BITS-1:0] dl_wd,
  output logic [PTR_W-1:0]       dl_ra_a,
  output logic [PTR_W-1:0]       dl_ra_b,
  output logic                   cf_we,
  output logic [CA_W-1:0]        cf_wa,
  output logic [COEF_BITS-1:0]   cf_wd,
  output logic [CA_W-1:0]        cf_ra
);

  localparam int IW = CA_W + COEF_IDX_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(TAPS - 1);
  localparam logic [PTR_W-1:0] HALF_SLOT = PTR_W'(HALF);
  localparam logic [CA_W-1:0]  LAST_STEP = CA_W'(HALF);
  localparam logic [IW-1:0]    HALF_IDX  = IW'(HALF);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] clr_r, clr_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] a_r, a_nxt;
  logic [PTR_W-1:0] b_r, b_nxt;
  logic [CA_W-1:0]  k_r, k_nxt;
  logic [PTR_W-1:0] wp_inc;
  logic [IW-1:0]    idx_w;
  logic             accept, flt_acc, cf_acc, clearing;

  assign accept   = in_valid && in_ready;
  assign flt_acc  = accept && (in_cmd == CMD_FILTER);
  assign cf_acc   = accept && (in_cmd == CMD_COEF);
  assign clearing = (state_r == S_CLEAR);
  assign idx_w    = IW'(in_coef_idx);
  assign wp_inc   = (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    wp_nxt    = wp_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (flt_acc) begin
          a_nxt     = wp_r;
          b_nxt     = wp_inc;
          wp_nxt    = wp_inc;
          k_nxt     = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        a_nxt = (a_r == '0) ? LAST_SLOT : a_r - 1'b1;
        b_nxt = (b_r == LAST_SLOT) ? '0 : b_r + 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == LAST_STEP) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (acc_done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      wp_r    <= '0;
      a_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wp_r    <= wp_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      k_r     <= k_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign ld_out   = (state_r == S_DONE) && !out_busy;

  assign ctl.clr_acc  = flt_acc;
  assign ctl.issue    = (state_r == S_RUN);
  assign ctl.last     = (k_r == LAST_STEP);
  assign ctl.shift_en = (state_r == S_SHIFT);

  // new sample lands at the acceptance edge, reads start next cycle
  assign dl_we   = clearing || flt_acc;
  assign dl_wa   = clearing ? clr_r : wp_r;
  assign dl_wd   = clearing ? '0 : in_sample;
  assign dl_ra_a = a_r;
  assign dl_ra_b = b_r;

  assign cf_we = clearing ? (clr_r <= HALF_SLOT) : (cf_acc && (idx_w <= HALF_IDX));
  assign cf_wa = clearing ? clr_r[CA_W-1:0] : idx_w[CA_W-1:0];
  assign cf_wd = clearing ? '0 : in_coef_val;
  assign cf_ra = k_r;

  a_start_newest: assert property (@(posedge clk) disable iff (!rst_n)
    flt_acc |=> state_r == S_RUN && k_r == '0 && a_r == $past(wp_r))
    else $error("tap walk does not start at the newest sample");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> state_r == S_DRAIN)
    else $error("accumulator finished outside drain");

  a_dl_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dl_we |-> state_r == S_CLEAR || state_r == S_IDLE)
    else $error("delay line written during a filter pass");

endmodule

// ----- hw/rtl/symmetric_fir_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_filter_top
// Odd-length linear-phase FIR filter, folded over one shared multiplier.
// ----------------------------------------------------------------------------
// Input items arrive on in_tvalid/in_tready/in_tdata with the kind on
// in_tuser: 0 filters in_tdata's sample, 1 writes one of the HALF+1 unique
// Q15 coefficients (indexes above HALF are dropped). A filter item yields
// one output item on out_tdata (saturated sample) with out_tuser set when
// saturation clipped it; a coefficient write yields nothing.
// cfg_wr_en/cfg_wr_data load the output right shift (reset 15).
// The delay line and coefficient store sit in synchronous RAMs; every tap
// pair is read, pre-added and multiplied once, one pair per cycle.
// A filter item runs to its end before the next acceptance: HALF+1 RAM
// reads, the pre-add, multiply and accumulate registers, shift, saturate.
// A coefficient write is taken in idle and leaves the block idle.
// After reset the block zeroes both RAMs with in_tready low. A result
// waits in the output register while the receiver stalls; a further
// filter item stops before its result until that register is taken.
// ----------------------------------------------------------------------------
module symmetric_fir_filter_top
  import sff_pkg::*;
#(
  parameter int TAPS        = 93,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  localparam int IN_W  = ((SAMPLE_BITS + COEF_IDX_W + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,   // sample_in, coef_index, coef_value
  input  logic               in_tuser,   // cmd
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // filtered
  output logic               out_tuser,  // clipped
  input  logic               cfg_wr_en,
  input  logic [SHIFT_W-1:0] cfg_wr_data // output_shift
);

  localparam int HALF  = (TAPS - 1) / 2;
  localparam int PTR_W = $clog2(TAPS);
  localparam int CA_W  = $clog2(HALF + 1);
  localparam int IDX_LO = SAMPLE_BITS;
  localparam int VAL_LO = SAMPLE_BITS + COEF_IDX_W;
  localparam logic [SAMPLE_BITS-1:0] POS_RAIL = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_RAIL = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  mac_ctl_t               ctl;
  logic [SHIFT_W-1:0]     shift_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] filtered_r;
  logic                   clipped_r;
  logic                   out_busy, ld_out, acc_done;
  logic                   dl_we, cf_we;
  logic [PTR_W-1:0]       dl_wa, dl_ra_a, dl_ra_b;
  logic [SAMPLE_BITS-1:0] dl_wd, dl_qa, dl_qb;
  logic [CA_W-1:0]        cf_wa, cf_ra;
  logic [COEF_BITS-1:0]   cf_wd, cf_q;
  logic [SAMPLE_BITS-1:0] sat_val;
  logic                   sat_clip;

  assign out_busy = out_valid_r && !out_tready;

  sff_seq #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_cmd      (in_tuser),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .in_coef_idx (in_tdata[VAL_LO-1:IDX_LO]),
    .in_coef_val (in_tdata[VAL_LO+COEF_BITS-1:VAL_LO]),
    .in_ready    (in_tready),
    .out_busy    (out_busy),
    .acc_done    (acc_done),
    .ld_out      (ld_out),
    .ctl         (ctl),
    .dl_we       (dl_we),
    .dl_wa       (dl_wa),
    .dl_wd       (dl_wd),
    .dl_ra_a     (dl_ra_a),
    .dl_ra_b     (dl_ra_b),
    .cf_we       (cf_we),
    .cf_wa       (cf_wa),
    .cf_wd       (cf_wd),
    .cf_ra       (cf_ra)
  );

  // two copies of the delay line give the newer and older tap of a pair
  sff_ram #(.W(SAMPLE_BITS), .D(TAPS)) u_dl_a (
    .clk (clk),
    .we  (dl_we),
    .wa  (dl_wa),
    .wd  (dl_wd),
    .ra  (dl_ra_a),
    .rq  (dl_qa)
  );

  sff_ram #(.W(SAMPLE_BITS), .D(TAPS)) u_dl_b (
    .clk (clk),
    .we  (dl_we),
    .wa  (dl_wa),
    .wd  (dl_wd),
    .ra  (dl_ra_b),
    .rq  (dl_qb)
  );

  sff_ram #(.W(COEF_BITS), .D(HALF + 1)) u_coef (
    .clk (clk),
    .we  (cf_we),
    .wa  (cf_wa),
    .wd  (cf_wd),
    .ra  (cf_ra),
    .rq  (cf_q)
  );

  sff_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .dl_qa     (dl_qa),
    .dl_qb     (dl_qb),
    .cf_q      (cf_q),
    .shift_amt (shift_r),
    .acc_done  (acc_done),
    .sat_val   (sat_val),
    .sat_clip  (sat_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        shift_r <= cfg_wr_data;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      filtered_r <= sat_val;
      clipped_r  <= sat_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(filtered_r);
  assign out_tuser  = clipped_r;

  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> filtered_r == POS_RAIL || filtered_r == NEG_RAIL)
    else $error("clipped item not at a rail");

endmodule

// ----- tb/symmetric_fir_filter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_filter_top_tb
// Self-checking bench for the folded symmetric FIR filter. A short table of
// directed items covers reset state, extreme samples and coefficients,
// dropped coefficient indexes, shift extremes and saturation in both
// directions. A random part follows in phases, each with its own output
// shift; every third phase reloads all coefficients. Results are checked
// in order, typed rows against the table, others against a behavioral
// model of the folded filter inside the bench. The sender works in bursts,
// the receiver stalls on its own pattern; a long hold-off backs up its input.
// ----------------------------------------------------------------------------
module symmetric_fir_filter_top_tb;
  import sff_pkg::*;

  localparam int TAPS        = 93;
  localparam int HALF        = (TAPS - 1) / 2;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int IN_W  = ((SAMPLE_BITS + COEF_IDX_W + COEF_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = HALF + 14;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int N_DIR         = 22;
  localparam int N_PHASE       = 10;
  localparam int PHASE_ITEMS   = 115;
  localparam int HOLD_AFTER    = 200;
  localparam int HOLD_CYCLES   = 800;
  localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;
  } fir_out_t;

  typedef enum logic {ROW_ITEM, ROW_SHIFT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;
    logic [COEF_IDX_W-1:0]  idx;
    logic [COEF_BITS-1:0]   value;
    logic [SHIFT_W-1:0]     shift;
    logic                   typed;
    logic [SAMPLE_BITS-1:0] exp_filtered;
    logic                   exp_clipped;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;   // sample_in, coef_index, coef_value, zero pad
  logic               in_tuser;   // cmd
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;  // filtered
  logic               out_tuser;  // clipped
  logic               cfg_wr_en;
  logic [SHIFT_W-1:0] cfg_wr_data; // output_shift

  logic signed [SAMPLE_BITS-1:0] tap_line [TAPS];
  logic signed [COEF_BITS-1:0]   coef_half [HALF+1];
  int                            wr_slot;
  int                            shift_amt;

  fir_out_t  pending_out [$];
  stim_row_t dir_tab [N_DIR];
  int        burst_left;
  int        mismatches;
  int        results_seen;
  int        cycle_count;

  symmetric_fir_filter_top #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic logic signed [SAMPLE_BITS-1:0] tap_at(int age);
    return tap_line[(wr_slot + TAPS - age) % TAPS];
  endfunction

  function automatic fir_out_t fold_filter(logic [SAMPLE_BITS-1:0] samp);
    longint   acc;
    longint   y;
    fir_out_t r;
    acc = 0;
    tap_line[wr_slot] = samp;
    for (int k = 0; k < HALF; k++) begin
      acc += longint'(coef_half[k]) * (longint'(tap_at(k)) + longint'(tap_at(TAPS - 1 - k)));
    end
    acc += longint'(coef_half[HALF]) * longint'(tap_at(HALF));
    wr_slot = (wr_slot + 1) % TAPS;
    y = acc >>> shift_amt;
    r.clipped = 1'b0;
    if (y > SAT_MAX) begin
      y = SAT_MAX;
      r.clipped = 1'b1;
    end else if (y < SAT_MIN) begin
      y = SAT_MIN;
      r.clipped = 1'b1;
    end
    r.filtered = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] samp,
                           input logic [COEF_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] val,
                           input logic typed, input fir_out_t typed_out);
    fir_out_t want;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_W - SAMPLE_BITS - COEF_IDX_W - COEF_BITS){1'b0}}, val, idx, samp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_FILTER) begin
      want = fold_filter(samp);
      pending_out.push_back(typed ? typed_out : want);
    end else if (idx <= HALF) begin
      coef_half[idx] = val;
    end
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic pause_sender();
    if (burst_left != 0) in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    pause_sender();
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_output_shift(input logic [SHIFT_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shift_amt = v;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef(int profile);
    case (profile)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 4095)) - 16'd2048;
      default: return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0000;
    endcase
  endfunction

  // receiver stall pattern with one long hold-off
  initial begin
    int stall_pct;
    int mode_left;
    int hold_left;
    bit hold_done;
    stall_pct  = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            2:       stall_pct = 70;
            default: stall_pct = 95;
          endcase
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : out_check
    fir_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        report_mismatch("result with nothing expected, filtered",
                        int'($signed(out_tdata[SAMPLE_BITS-1:0])), 0);
      end else begin
        want = pending_out.pop_front();
        if (out_tdata[SAMPLE_BITS-1:0] !== want.filtered)
          report_mismatch("filtered", int'($signed(out_tdata[SAMPLE_BITS-1:0])),
                          int'(want.filtered));
        if (out_tuser !== want.clipped)
          report_mismatch("clipped", int'(out_tuser), int'(want.clipped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fir_out_t typed_out;
    logic     cmd;
    logic [COEF_IDX_W-1:0] idx;
    int       profile;
    int       phase_items;
    int       shift_plan [N_PHASE];

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_FILTER;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    burst_left   = 0;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;
    wr_slot      = 0;
    shift_amt    = SHIFT_RESET;
    for (int k = 0; k < TAPS; k++) tap_line[k] = '0;
    for (int k = 0; k <= HALF; k++) coef_half[k] = '0;

    // kind, cmd, sample, index, value, shift, typed, filtered, clipped
    dir_tab = '{
      '{ROW_ITEM,  CMD_FILTER, 16'h7fff, 6'h3f, 16'hffff, 5'd0,  1'b1, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h8000, 6'h00, 16'h0000, 5'd0,  1'b1, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'hffff, 6'd0,  16'h8000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'h0000, 6'd46, 16'h7fff, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'h1234, 6'd47, 16'h3039, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'h0000, 6'h3f, 16'hffff, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd0,  1'b1, 16'h0000, 1'b0},
      '{ROW_SHIFT, CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h7fff, 6'h00, 16'h0000, 5'd0,  1'b1, 16'h8000, 1'b1},
      '{ROW_ITEM,  CMD_FILTER, 16'h8000, 6'h00, 16'h0000, 5'd0,  1'b1, 16'h7fff, 1'b1},
      '{ROW_SHIFT, CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd31, 1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h0001, 6'h00, 16'h0000, 5'd0,  1'b1, 16'hffff, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd0,  1'b1, 16'h0000, 1'b0},
      '{ROW_SHIFT, CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd15, 1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'hffff, 6'h2a, 16'h5555, 5'd0,  1'b1, 16'h0001, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'h0000, 6'd1,  16'h4000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_COEF,   16'h0000, 6'd45, 16'hc000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h7fff, 6'h00, 16'h0000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h8000, 6'h00, 16'h0000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_SHIFT, CMD_FILTER, 16'h0000, 6'h00, 16'h0000, 5'd16, 1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h1234, 6'h00, 16'h0000, 5'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_ITEM,  CMD_FILTER, 16'h8000, 6'h00, 16'h0000, 5'd0,  1'b0, 16'h0000, 1'b0}
    };
    shift_plan = '{15, 0, 31, 14, 9, 20, 15, 1, 30, 16};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_SHIFT) begin
        set_output_shift(dir_tab[r].shift);
      end else begin
        typed_out.filtered = dir_tab[r].exp_filtered;
        typed_out.clipped  = dir_tab[r].exp_clipped;
        send_item(dir_tab[r].cmd, dir_tab[r].sample, dir_tab[r].idx, dir_tab[r].value,
                  dir_tab[r].typed, typed_out);
      end
    end

    typed_out = '0;
    for (int p = 0; p < N_PHASE; p++) begin
      set_output_shift((p == N_PHASE - 1) ? SHIFT_W'($urandom) : SHIFT_W'(shift_plan[p]));
      phase_items = 0;
      profile = $urandom_range(0, 2);
      if (p % 3 == 0) begin
        for (int k = 0; k <= HALF; k++) begin
          send_item(CMD_COEF, 16'($urandom), COEF_IDX_W'(k), rand_coef(profile), 1'b0,
                    typed_out);
          phase_items++;
        end
      end
      while (phase_items < PHASE_ITEMS) begin
        cmd = ($urandom_range(0, 99) < 15) ? CMD_COEF : CMD_FILTER;
        idx = ($urandom_range(0, 9) == 0) ? COEF_IDX_W'($urandom) :
                                            COEF_IDX_W'($urandom_range(0, HALF));
        send_item(cmd, rand_sample(), idx, rand_coef(profile), 1'b0, typed_out);
        phase_items++;
      end
    end

    wait_drained();
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sff_pkg.sv
hw/rtl/sff_ram.sv
hw/rtl/sff_mac.sv
hw/rtl/sff_seq.sv
hw/rtl/symmetric_fir_filter_top.sv
tb/symmetric_fir_filter_top_tb.sv
